// ===== src/lscc_pkg.sv =====
`default_nettype none

package lscc_pkg;

	// Window geometry and line limits
	localparam int HALF_WINDOW     = 5;
	localparam int WIN_LEN         = 2 * HALF_WINDOW + 1;
	localparam int MAX_LINE_POINTS = 4096;
	localparam int COORD_BITS      = 20;

	// Count holds 0..MAX_LINE_POINTS inclusive
	localparam int CNT_W = $clog2(MAX_LINE_POINTS) + 1;
	localparam int IDX_W = 12;

	// Register and result field widths
	localparam int LIM_W   = 40;
	localparam int THR_W   = 49;
	localparam int LEFT_W  = 47;
	localparam int RIGHT_W = 50;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 49;

	// Squared planar range, and the width it is compared at
	localparam int RSQ_W = 2 * COORD_BITS;
	localparam int CMP_W = (RSQ_W > LIM_W) ? RSQ_W : LIM_W;

	// Difference vectors: total uses 2*HALF_WINDOW neighbors, left uses HALF_WINDOW
	localparam int DT_W  = COORD_BITS + $clog2(4 * HALF_WINDOW);
	localparam int DL_W  = COORD_BITS + $clog2(2 * HALF_WINDOW);
	localparam int SQT_W = 2 * DT_W;
	localparam int SQL_W = 2 * DL_W;
	localparam int TOT_W = SQT_W + 2;
	localparam int LFT_W = SQL_W + 2;

	// Saturation compare widths
	localparam int TX_W = (TOT_W > THR_W) ? TOT_W : THR_W;
	localparam int LX_W = (LFT_W > LEFT_W) ? LFT_W : LEFT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_RANGE = 2'd0,
		CFG_MAX_RANGE = 2'd1,
		CFG_EDGE_THR  = 2'd2
	} cfg_reg_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	// Point after the range square stage
	typedef struct packed {
		logic             valid;
		logic             last;
		point_t           pt;
		logic [RSQ_W-1:0] rsq;
	} gate_t;

	// Result control riding along the curvature pipeline
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] index;
	} res_ctl_t;

endpackage

`default_nettype wire

// ===== src/lidar_scanline_curvature_classifier.sv =====
`default_nettype none

// Scan-line curvature classifier. Takes one lidar point per clock (x, y, z in
// millimetres), keeps points whose x*x + y*y lies within [min_range_sq,
// max_range_sq], and slides them through an 11-point window; once the window
// is full each kept point gives one result for the window's centre: the squared
// norm of the ten-neighbor sum minus ten times the centre, the left-half term,
// their difference, and an edge flag (total above edge_threshold). line_end
// restarts the window for the next line. Throughput is one point per clock
// outside stalls; results pass the input, range, window, difference, square,
// sum and result registers. The whole pipeline stalls together while a result
// waits on out_ready. Write configuration only while no transaction is in flight.
module lidar_scanline_curvature_classifier (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration
	input  wire                                  cfg_we,
	input  wire  [lscc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [lscc_pkg::CFG_W-1:0]           cfg_wdata,
	// point input
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  signed [lscc_pkg::COORD_BITS-1:0] pos_x,
	input  wire  signed [lscc_pkg::COORD_BITS-1:0] pos_y,
	input  wire  signed [lscc_pkg::COORD_BITS-1:0] pos_z,
	input  wire                                  line_end,
	// result output
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [lscc_pkg::IDX_W-1:0]           point_index,
	output logic signed [lscc_pkg::COORD_BITS-1:0] centre_x,
	output logic signed [lscc_pkg::COORD_BITS-1:0] centre_y,
	output logic signed [lscc_pkg::COORD_BITS-1:0] centre_z,
	output logic [lscc_pkg::THR_W-1:0]           curvature_total,
	output logic [lscc_pkg::LEFT_W-1:0]          curvature_left,
	output logic signed [lscc_pkg::RIGHT_W-1:0]  curvature_right,
	output logic                                 is_edge
);

	logic [lscc_pkg::LIM_W-1:0] min_range_q;
	logic [lscc_pkg::LIM_W-1:0] max_range_q;
	logic [lscc_pkg::THR_W-1:0] edge_thr_q;
	logic                       adv;
	lscc_pkg::gate_t            gate_s2;
	lscc_pkg::res_ctl_t         ctl_s3;
	lscc_pkg::point_t           win [lscc_pkg::WIN_LEN];
	lscc_pkg::point_t           centre;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= '0;
			max_range_q <= {1'b1, {(lscc_pkg::LIM_W-1){1'b0}}};
			edge_thr_q  <= '0;
		end else if (cfg_we) begin
			case (lscc_pkg::cfg_reg_t'(cfg_index))
				lscc_pkg::CFG_MIN_RANGE: min_range_q <= cfg_wdata[lscc_pkg::LIM_W-1:0];
				lscc_pkg::CFG_MAX_RANGE: max_range_q <= cfg_wdata[lscc_pkg::LIM_W-1:0];
				lscc_pkg::CFG_EDGE_THR:  edge_thr_q  <= cfg_wdata[lscc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline advances unless a finished result is held
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	lscc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.line_end (line_end),
		.gate_s2  (gate_s2)
	);

	lscc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.gate_s2   (gate_s2),
		.min_range (min_range_q),
		.max_range (max_range_q),
		.ctl_s3    (ctl_s3),
		.win       (win)
	);

	lscc_curv u_curv (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_s3      (ctl_s3),
		.win         (win),
		.edge_thr    (edge_thr_q),
		.out_valid_q (out_valid),
		.index_q     (point_index),
		.centre_q    (centre),
		.total_q     (curvature_total),
		.left_q      (curvature_left),
		.right_q     (curvature_right),
		.edge_q      (is_edge)
	);

	assign centre_x = centre.x;
	assign centre_y = centre.y;
	assign centre_z = centre.z;

endmodule

`default_nettype wire

// ===== src/lscc_front.sv =====
`default_nettype none

module lscc_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   adv,
	input  wire                   in_valid,
	input  wire  lscc_pkg::coord_t pos_x,
	input  wire  lscc_pkg::coord_t pos_y,
	input  wire  lscc_pkg::coord_t pos_z,
	input  wire                   line_end,
	output lscc_pkg::gate_t       gate_s2
);

	logic                valid_s1;
	logic                last_s1;
	lscc_pkg::point_t    pt_s1;
	logic                valid_s2;
	logic                last_s2;
	lscc_pkg::point_t    pt_s2;
	logic [lscc_pkg::RSQ_W-1:0]        rsq_s2;
	logic signed [lscc_pkg::RSQ_W-1:0] xx;
	logic signed [lscc_pkg::RSQ_W-1:0] yy;
	logic [lscc_pkg::RSQ_W-1:0]        rsq;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Input register, then squared planar range register
	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1.x <= pos_x;
			pt_s1.y <= pos_y;
			pt_s1.z <= pos_z;
			last_s1 <= line_end;
			last_s2 <= last_s1;
			pt_s2   <= pt_s1;
			rsq_s2  <= rsq;
		end
	end

	// x*x + y*y, both squares non-negative
	always_comb begin
		xx  = pt_s1.x * pt_s1.x;
		yy  = pt_s1.y * pt_s1.y;
		rsq = $unsigned(xx) + $unsigned(yy);
	end

	assign gate_s2 = '{valid: valid_s2, last: last_s2, pt: pt_s2, rsq: rsq_s2};

endmodule

`default_nettype wire

// ===== src/lscc_window.sv =====
`default_nettype none

module lscc_window (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         adv,
	input  wire  lscc_pkg::gate_t       gate_s2,
	input  wire  [lscc_pkg::LIM_W-1:0]  min_range,
	input  wire  [lscc_pkg::LIM_W-1:0]  max_range,
	output lscc_pkg::res_ctl_t          ctl_s3,
	output lscc_pkg::point_t            win [lscc_pkg::WIN_LEN]
);

	logic [lscc_pkg::CNT_W-1:0] cnt_q;
	lscc_pkg::point_t           win_q [lscc_pkg::WIN_LEN];
	logic [lscc_pkg::CMP_W-1:0] rsq_x;
	logic [lscc_pkg::CMP_W-1:0] min_x;
	logic [lscc_pkg::CMP_W-1:0] max_x;
	logic                       take;
	logic                       full;

	// Range gate and line length limit
	always_comb begin
		rsq_x = lscc_pkg::CMP_W'(gate_s2.rsq);
		min_x = lscc_pkg::CMP_W'(min_range);
		max_x = lscc_pkg::CMP_W'(max_range);
		take  = gate_s2.valid && (rsq_x >= min_x) && (rsq_x <= max_x) &&
			(cnt_q < lscc_pkg::CNT_W'(lscc_pkg::MAX_LINE_POINTS));
		// window is full once this point lands
		full  = cnt_q >= lscc_pkg::CNT_W'(lscc_pkg::WIN_LEN - 1);
	end

	// Point count and result control; line end clears the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3.valid <= take && full;
			ctl_s3.index <= lscc_pkg::IDX_W'(cnt_q -
				lscc_pkg::CNT_W'(lscc_pkg::HALF_WINDOW));
			if (gate_s2.valid && gate_s2.last) begin
				cnt_q <= '0;
			end else if (take) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Window shift line; stale entries are never read before the count refills it
	always_ff @(posedge clk) begin
		if (adv && take) begin
			for (int i = 0; i < lscc_pkg::WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[lscc_pkg::WIN_LEN-1] <= gate_s2.pt;
		end
	end

	assign win = win_q;

endmodule

`default_nettype wire

// ===== src/lscc_curv.sv =====
`default_nettype none

module lscc_curv (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 adv,
	input  wire  lscc_pkg::res_ctl_t            ctl_s3,
	input  wire  lscc_pkg::point_t              win [lscc_pkg::WIN_LEN],
	input  wire  [lscc_pkg::THR_W-1:0]          edge_thr,
	output logic                                out_valid_q,
	output logic [lscc_pkg::IDX_W-1:0]          index_q,
	output lscc_pkg::point_t                    centre_q,
	output logic [lscc_pkg::THR_W-1:0]          total_q,
	output logic [lscc_pkg::LEFT_W-1:0]         left_q,
	output logic signed [lscc_pkg::RIGHT_W-1:0] right_q,
	output logic                                edge_q
);

	localparam int HW = lscc_pkg::HALF_WINDOW;
	localparam int WL = lscc_pkg::WIN_LEN;

	lscc_pkg::coord_t                   ax [3][WL];
	logic signed [lscc_pkg::DT_W-1:0]   sum_t [3];
	logic signed [lscc_pkg::DL_W-1:0]   sum_l [3];
	logic signed [lscc_pkg::DT_W-1:0]   c_t [3];
	logic signed [lscc_pkg::DL_W-1:0]   c_l [3];
	logic signed [lscc_pkg::DT_W-1:0]   dt [3];
	logic signed [lscc_pkg::DL_W-1:0]   dl [3];
	logic signed [lscc_pkg::SQT_W-1:0]  pt [3];
	logic signed [lscc_pkg::SQL_W-1:0]  pl [3];

	lscc_pkg::res_ctl_t                 ctl_s4, ctl_s5, ctl_s6;
	lscc_pkg::point_t                   centre_s4, centre_s5, centre_s6;
	logic signed [lscc_pkg::DT_W-1:0]   dt_s4 [3];
	logic signed [lscc_pkg::DL_W-1:0]   dl_s4 [3];
	logic [lscc_pkg::SQT_W-1:0]         sqt_s5 [3];
	logic [lscc_pkg::SQL_W-1:0]         sql_s5 [3];
	logic [lscc_pkg::TOT_W-1:0]         total_s6;
	logic [lscc_pkg::LFT_W-1:0]         left_s6;

	logic [lscc_pkg::TX_W-1:0]          tot_x;
	logic [lscc_pkg::LX_W-1:0]          lft_x;
	logic [lscc_pkg::THR_W-1:0]         tot_sat;
	logic [lscc_pkg::LEFT_W-1:0]        lft_sat;

	// Neighbor sums and differences against the scaled centre
	always_comb begin
		for (int i = 0; i < WL; i++) begin
			ax[0][i] = win[i].x;
			ax[1][i] = win[i].y;
			ax[2][i] = win[i].z;
		end
		for (int a = 0; a < 3; a++) begin
			sum_l[a] = '0;
			sum_t[a] = '0;
			for (int i = 0; i < HW; i++) begin
				sum_l[a] = sum_l[a] + lscc_pkg::DL_W'(ax[a][i]);
			end
			for (int i = 0; i < WL; i++) begin
				if (i != HW) begin
					sum_t[a] = sum_t[a] + lscc_pkg::DT_W'(ax[a][i]);
				end
			end
			c_t[a] = lscc_pkg::DT_W'(ax[a][HW]);
			c_l[a] = lscc_pkg::DL_W'(ax[a][HW]);
			dt[a]  = sum_t[a] - c_t[a] * lscc_pkg::DT_W'(2 * HW);
			dl[a]  = sum_l[a] - c_l[a] * lscc_pkg::DL_W'(HW);
		end
	end

	// Squares of the difference components
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pt[a] = dt_s4[a] * dt_s4[a];
			pl[a] = dl_s4[a] * dl_s4[a];
		end
	end

	// Saturation of the total and left terms
	always_comb begin
		tot_x   = lscc_pkg::TX_W'(total_s6);
		lft_x   = lscc_pkg::LX_W'(left_s6);
		tot_sat = (tot_x > lscc_pkg::TX_W'({lscc_pkg::THR_W{1'b1}})) ?
			{lscc_pkg::THR_W{1'b1}} : tot_x[lscc_pkg::THR_W-1:0];
		lft_sat = (lft_x > lscc_pkg::LX_W'({lscc_pkg::LEFT_W{1'b1}})) ?
			{lscc_pkg::LEFT_W{1'b1}} : lft_x[lscc_pkg::LEFT_W-1:0];
	end

	// Control along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4      <= '0;
			ctl_s5      <= '0;
			ctl_s6      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			ctl_s4      <= ctl_s3;
			ctl_s5      <= ctl_s4;
			ctl_s6      <= ctl_s5;
			out_valid_q <= ctl_s6.valid;
		end
	end

	// Datapath stages and result register
	always_ff @(posedge clk) begin
		if (adv) begin
			centre_s4 <= win[HW];
			centre_s5 <= centre_s4;
			centre_s6 <= centre_s5;
			for (int a = 0; a < 3; a++) begin
				dt_s4[a]  <= dt[a];
				dl_s4[a]  <= dl[a];
				sqt_s5[a] <= $unsigned(pt[a]);
				sql_s5[a] <= $unsigned(pl[a]);
			end
			total_s6 <= lscc_pkg::TOT_W'(sqt_s5[0]) + lscc_pkg::TOT_W'(sqt_s5[1]) +
				lscc_pkg::TOT_W'(sqt_s5[2]);
			left_s6  <= lscc_pkg::LFT_W'(sql_s5[0]) + lscc_pkg::LFT_W'(sql_s5[1]) +
				lscc_pkg::LFT_W'(sql_s5[2]);
			index_q  <= ctl_s6.index;
			centre_q <= centre_s6;
			total_q  <= tot_sat;
			left_q   <= lft_sat;
			right_q  <= $signed(lscc_pkg::RIGHT_W'(tot_sat) - lscc_pkg::RIGHT_W'(lft_sat));
			edge_q   <= tot_x > lscc_pkg::TX_W'(edge_thr);
		end
	end

endmodule

`default_nettype wire
